### sv/cpdb_pkg.sv
// Shared types and constants for the complementary PWM block.
// No dependencies; every other file depends on this package.
package cpdb_pkg;

   localparam int COUNTER_BITS_DEFAULT = 16;
   localparam int DELAY_BITS_DEFAULT   = 10;

   // Fixed widths of the transaction fields and configuration port
   localparam int CMD_BITS       = 3;
   localparam int VALUE_BITS     = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK          = 3'd0,
      CMD_WRITE_COMPARE = 3'd1,
      CMD_WRITE_PERIOD  = 3'd2,
      CMD_FORCE_TRIP    = 3'd3,
      CMD_CLEAR_TRIP    = 3'd4,
      CMD_SET_FORCE     = 3'd5
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEAD_BAND_ENABLE = 2'd0,
      CSR_DEAD_BAND_DELAY  = 2'd1,
      CSR_TRIP_ENABLE      = 2'd2
   } csr_index_type;

   // Time base / action qualifier view after the current step
   typedef struct packed {
      logic level;       // qualifier level after this step
      logic level_prev;  // qualifier level before this step
      logic zero_event;  // counter reached zero on this tick
   } tb_status_type;

   // Dead-band outputs after the current step
   typedef struct packed {
      logic a;
      logic b;
   } db_status_type;

endpackage

### sv/cpdb_if.sv
// Handshake interfaces for the request and response channels.
// Depends on cpdb_pkg for field widths.
interface cpdb_req_if;
   logic                              valid;
   logic                              ready;
   logic [cpdb_pkg::CMD_BITS-1:0]     cmd;
   logic [cpdb_pkg::VALUE_BITS-1:0]   value;
   logic                              trip_pin;

   modport source (output valid, output cmd, output value, output trip_pin, input ready);
   modport sink   (input valid, input cmd, input value, input trip_pin, output ready);
endinterface

interface cpdb_rsp_if;
   logic valid;
   logic ready;
   logic pwm_a;
   logic pwm_b;
   logic adc_trigger;
   logic trip_latched;
   logic trip_interrupt;

   modport source (output valid, output pwm_a, output pwm_b, output adc_trigger,
                   output trip_latched, output trip_interrupt, input ready);
   modport sink   (input valid, input pwm_a, input pwm_b, input adc_trigger,
                   input trip_latched, input trip_interrupt, output ready);
endinterface

### sv/cpdb_timebase.sv
// Up-down counter, shadowed period/compare and action qualifier.
// Depends on cpdb_pkg.
module cpdb_timebase #(
   parameter int COUNTER_BITS = cpdb_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  cpdb_pkg::cmd_type                 cmd,
   input  logic [cpdb_pkg::VALUE_BITS-1:0]   value,
   output cpdb_pkg::tb_status_type           status
);
   import cpdb_pkg::*;

   logic [COUNTER_BITS-1:0] counter_ff, counter_in;
   logic                    count_down_ff, count_down_in;
   logic [COUNTER_BITS-1:0] period_active_ff, period_active_in;
   logic [COUNTER_BITS-1:0] period_shadow_ff, period_shadow_in;
   logic [COUNTER_BITS-1:0] compare_active_ff, compare_active_in;
   logic [COUNTER_BITS-1:0] compare_shadow_ff, compare_shadow_in;
   logic                    level_ff, level_in;
   logic                    force_high_ff, force_high_in;

   logic [COUNTER_BITS+VALUE_BITS-1:0] value_wide;
   logic [COUNTER_BITS-1:0]            value_cnt;
   logic                               moved_up;
   logic                               zero_event;

   // Zero-extend then cut to the counter width
   assign value_wide = {{COUNTER_BITS{1'b0}}, value};
   assign value_cnt  = value_wide[COUNTER_BITS-1:0];

   always_comb begin
      counter_in        = counter_ff;
      count_down_in     = count_down_ff;
      period_active_in  = period_active_ff;
      period_shadow_in  = period_shadow_ff;
      compare_active_in = compare_active_ff;
      compare_shadow_in = compare_shadow_ff;
      level_in          = level_ff;
      force_high_in     = force_high_ff;
      moved_up          = 1'b0;
      zero_event        = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (!count_down_ff) begin
               if (counter_ff >= period_active_ff) begin
                  count_down_in = 1'b1;
                  if (counter_ff != '0) counter_in = counter_ff - 1'b1;
               end else begin
                  counter_in = counter_ff + 1'b1;
                  moved_up   = 1'b1;
               end
            end else begin
               if (counter_ff == '0) begin
                  count_down_in = 1'b0;
                  if (period_active_ff != '0) begin
                     counter_in = COUNTER_BITS'(1);
                     moved_up   = 1'b1;
                  end
               end else begin
                  counter_in = counter_ff - 1'b1;
               end
            end
            if (counter_in != counter_ff && counter_in == compare_active_ff)
               level_in = !moved_up;
            zero_event = (counter_in == '0);
            if (zero_event) begin
               period_active_in  = period_shadow_ff;
               compare_active_in = compare_shadow_ff;
            end
            if (force_high_ff) level_in = 1'b1;
         end
         CMD_WRITE_COMPARE: compare_shadow_in = value_cnt;
         CMD_WRITE_PERIOD:  period_shadow_in  = value_cnt;
         CMD_SET_FORCE:     force_high_in     = value[0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff        <= '0;
         count_down_ff     <= 1'b0;
         period_active_ff  <= '0;
         period_shadow_ff  <= '0;
         compare_active_ff <= '0;
         compare_shadow_ff <= '0;
         level_ff          <= 1'b0;
         force_high_ff     <= 1'b0;
      end else if (step) begin
         counter_ff        <= counter_in;
         count_down_ff     <= count_down_in;
         period_active_ff  <= period_active_in;
         period_shadow_ff  <= period_shadow_in;
         compare_active_ff <= compare_active_in;
         compare_shadow_ff <= compare_shadow_in;
         level_ff          <= level_in;
         force_high_ff     <= force_high_in;
      end
   end

   assign status.level      = level_in;
   assign status.level_prev = level_ff;
   assign status.zero_event = zero_event;

endmodule

### sv/cpdb_dead_band.sv
// Dead-band edge delay producing the complementary A/B pair.
// Depends on cpdb_pkg.
module cpdb_dead_band #(
   parameter int DELAY_BITS = cpdb_pkg::DELAY_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     tick,
   input  logic [DELAY_BITS-1:0]    limit,
   input  cpdb_pkg::tb_status_type  tb,
   output cpdb_pkg::db_status_type  status
);
   import cpdb_pkg::*;

   logic [DELAY_BITS-1:0] edge_count_ff, edge_count_in;
   logic                  delayed_a_ff, delayed_a_in;
   logic                  delayed_b_ff, delayed_b_in;
   logic                  settled;

   always_comb begin
      edge_count_in = edge_count_ff;
      delayed_a_in  = delayed_a_ff;
      delayed_b_in  = delayed_b_ff;
      settled       = 1'b0;
      if (tick) begin
         // Restart on a level change, saturate at the delay
         if (tb.level != tb.level_prev)
            edge_count_in = '0;
         else if (edge_count_ff < limit)
            edge_count_in = edge_count_ff + 1'b1;
         settled      = (edge_count_in >= limit);
         delayed_a_in = tb.level && settled;
         delayed_b_in = !tb.level && settled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         delayed_a_ff  <= 1'b0;
         delayed_b_ff  <= 1'b1;
      end else if (step) begin
         edge_count_ff <= edge_count_in;
         delayed_a_ff  <= delayed_a_in;
         delayed_b_ff  <= delayed_b_in;
      end
   end

   assign status.a = delayed_a_in;
   assign status.b = delayed_b_in;

endmodule

### sv/complementary_pwm_dead_band_trip.sv
// Center-aligned PWM with dead band and one-shot trip latch: top level.
// Path: an accepted request waits in the input register and moves into the result
// register when that is free; the response is then valid, and rsp stalls hold it.
// Throughput: one transaction per cycle unless rsp stalls; the next transaction
// depends only on state updated in the compute step between input and result register.
// Reset (synchronous, active high) clears valid, control and config state; data registers are not reset.
// Depends on cpdb_pkg, cpdb_if, cpdb_timebase and cpdb_dead_band.
module complementary_pwm_dead_band_trip #(
   parameter int COUNTER_BITS = cpdb_pkg::COUNTER_BITS_DEFAULT,
   parameter int DELAY_BITS   = cpdb_pkg::DELAY_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   cpdb_req_if.sink                              req,
   cpdb_rsp_if.source                            rsp,
   input  logic                                  csr_write_enable,
   input  logic [cpdb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cpdb_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import cpdb_pkg::*;

   // Configuration registers
   logic                     dead_band_enable_ff;
   logic [CSR_DATA_BITS-1:0] dead_band_delay_ff;
   logic                     trip_enable_ff;

   // Input register stage
   logic                     in_valid_ff;
   logic [CMD_BITS-1:0]      cmd_ff;
   logic [VALUE_BITS-1:0]    value_ff;
   logic                     trip_pin_ff;

   // Result register stage
   logic rsp_valid_ff, rsp_valid_in;
   logic pwm_a_ff, pwm_a_in;
   logic pwm_b_ff, pwm_b_in;
   logic adc_trigger_ff;
   logic trip_latch_ff, trip_latch_in;

   logic                          advance;
   logic                          tick;
   cmd_type                       cmd;
   tb_status_type                 tb_status;
   db_status_type                 db_status;
   logic [DELAY_BITS+CSR_DATA_BITS-1:0] delay_wide;
   logic [DELAY_BITS-1:0]         delay_limit;

   // Move the held transaction into the result register when it is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign cmd       = cmd_type'(cmd_ff);
   assign tick      = (cmd == CMD_TICK);

   // Fit the delay register to the edge counter width
   assign delay_wide  = {{DELAY_BITS{1'b0}}, dead_band_delay_ff};
   assign delay_limit = delay_wide[DELAY_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_band_enable_ff <= 1'b1;
         dead_band_delay_ff  <= '0;
         trip_enable_ff      <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_DEAD_BAND_ENABLE: dead_band_enable_ff <= csr_write_data[0];
            CSR_DEAD_BAND_DELAY:  dead_band_delay_ff  <= csr_write_data;
            CSR_TRIP_ENABLE:      trip_enable_ff      <= csr_write_data[0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Input register: hold a transaction until the compute stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         cmd_ff      <= req.cmd;
         value_ff    <= req.value;
         trip_pin_ff <= req.trip_pin;
      end
   end

   cpdb_timebase #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_timebase (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cmd    (cmd),
      .value  (value_ff),
      .status (tb_status)
   );

   cpdb_dead_band #(
      .DELAY_BITS (DELAY_BITS)
   ) u_dead_band (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .tick   (tick),
      .limit  (delay_limit),
      .tb     (tb_status),
      .status (db_status)
   );

   // Trip latch: set by pin on a tick or by software, cleared by software
   always_comb begin
      trip_latch_in = trip_latch_ff;
      case (cmd)
         CMD_TICK:       if (trip_enable_ff && trip_pin_ff) trip_latch_in = 1'b1;
         CMD_FORCE_TRIP: trip_latch_in = 1'b1;
         CMD_CLEAR_TRIP: trip_latch_in = 1'b0;
         default: ;
      endcase
   end

   // Output selection: dead band or raw level, then trip override
   always_comb begin
      if (dead_band_enable_ff) begin
         pwm_a_in = db_status.a;
         pwm_b_in = db_status.b;
      end else begin
         pwm_a_in = tb_status.level;
         pwm_b_in = tb_status.level;
      end
      if (trip_latch_in) begin
         pwm_a_in = 1'b1;
         pwm_b_in = 1'b0;
      end
   end

   always_comb begin
      if (advance)
         rsp_valid_in = 1'b1;
      else if (rsp.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         trip_latch_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) trip_latch_ff <= trip_latch_in;
      end
      if (advance) begin
         pwm_a_ff       <= pwm_a_in;
         pwm_b_ff       <= pwm_b_in;
         adc_trigger_ff <= tb_status.zero_event;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.pwm_a          = pwm_a_ff;
   assign rsp.pwm_b          = pwm_b_ff;
   assign rsp.adc_trigger    = adc_trigger_ff;
   assign rsp.trip_latched   = trip_latch_ff;
   assign rsp.trip_interrupt = trip_latch_ff;

endmodule

### dv/tb_top.sv
// Testbench for the center-aligned PWM block with dead band and trip latch.
// Drives request transactions and CSR writes, predicts every response in-line
// and checks it field by field. Depends on cpdb_pkg, cpdb_if and the RTL top.
module tb_top;
   import cpdb_pkg::*;

   // Command codes the package leaves unnamed; the block must ignore them
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_LO = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_HI = 3'd7;

   localparam int CNT_W        = COUNTER_BITS_DEFAULT;
   localparam int DLY_W        = DELAY_BITS_DEFAULT;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_GAP      = 10;
   localparam int SETTLE_TICKS = 4;

   // One response as the block should present it
   typedef struct packed {
      logic pwm_a;
      logic pwm_b;
      logic adc_trigger;
      logic trip_latched;
      logic trip_interrupt;
   } pwm_outputs_type;

   logic clock;
   logic reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   cpdb_req_if req_ch ();
   cpdb_rsp_if rsp_ch ();

   complementary_pwm_dead_band_trip dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Expected responses, oldest first
   pwm_outputs_type pending_outputs[$];

   int  fail_count     = 0;
   int  response_count = 0;
   int  cycle_count    = 0;
   // Clear to run a stretch without any idling on either side
   bit  gaps_on        = 1'b1;
   // Set by the back-pressure test; the response side consumes it once
   int  hold_off_cycles = 0;

   // ---------------------------------------------------------------------------
   // Predictor state: configuration copy and the block's own registers
   // ---------------------------------------------------------------------------
   logic             cfg_db_on;
   logic [DLY_W-1:0] cfg_db_ticks;
   logic             cfg_trip_on;

   logic [CNT_W-1:0] tb_count;
   logic             tb_down;
   logic [CNT_W-1:0] per_live, per_next;
   logic [CNT_W-1:0] cmp_live, cmp_next;
   logic             aq_level;
   logic [DLY_W-1:0] db_count;
   logic             db_a, db_b;
   logic             trip_set, trip_irq;
   logic             force_on;

   task automatic reset_pwm_model();
      cfg_db_on    = 1'b1;
      cfg_db_ticks = '0;
      cfg_trip_on  = 1'b1;
      tb_count     = '0;
      tb_down      = 1'b0;
      per_live     = '0;
      per_next     = '0;
      cmp_live     = '0;
      cmp_next     = '0;
      aq_level     = 1'b0;
      db_count     = '0;
      db_a         = 1'b0;
      db_b         = 1'b1;
      trip_set     = 1'b0;
      trip_irq     = 1'b0;
      force_on     = 1'b0;
   endtask

   // Advance the predicted time base, qualifier, dead band and trip by one tick;
   // return whether the counter landed on zero
   function automatic logic advance_time_base(logic pin);
      logic [CNT_W-1:0] prev_count;
      logic             prev_level;
      logic             moved_up;
      logic             at_zero;
      logic             settled;
      prev_count = tb_count;
      prev_level = aq_level;
      moved_up   = 1'b0;

      // Up-down count with turnaround at the period and at zero
      if (!tb_down) begin
         if (tb_count >= per_live) begin
            tb_down = 1'b1;
            if (tb_count != '0) tb_count = tb_count - 1'b1;
         end else begin
            tb_count = tb_count + 1'b1;
            moved_up = 1'b1;
         end
      end else if (tb_count == '0) begin
         tb_down = 1'b0;
         if (per_live != '0) begin
            tb_count = CNT_W'(1);
            moved_up = 1'b1;
         end
      end else begin
         tb_count = tb_count - 1'b1;
      end

      // Compare match only when the counter actually moved onto the compare
      if (tb_count != prev_count && tb_count == cmp_live) aq_level = !moved_up;

      // Shadow registers load on the zero event
      at_zero = (tb_count == '0);
      if (at_zero) begin
         per_live = per_next;
         cmp_live = cmp_next;
      end

      if (force_on) aq_level = 1'b1;

      // Edge counter restarts on any level change and saturates at the delay
      if (aq_level != prev_level) db_count = '0;
      else if (db_count < cfg_db_ticks) db_count = db_count + 1'b1;
      settled = (db_count >= cfg_db_ticks);
      db_a    = aq_level && settled;
      db_b    = !aq_level && settled;

      if (cfg_trip_on && pin) begin
         trip_set = 1'b1;
         trip_irq = 1'b1;
      end
      return at_zero;
   endfunction

   // Apply one accepted request to the predictor and return its response
   function automatic pwm_outputs_type predict_pwm_outputs(logic [CMD_BITS-1:0] cmd,
                                                           logic [VALUE_BITS-1:0] value,
                                                           logic pin);
      pwm_outputs_type outs;
      logic            at_zero;
      at_zero = 1'b0;
      case (cmd)
         CMD_TICK:          at_zero  = advance_time_base(pin);
         CMD_WRITE_COMPARE: cmp_next = value[CNT_W-1:0];
         CMD_WRITE_PERIOD:  per_next = value[CNT_W-1:0];
         CMD_FORCE_TRIP: begin
            trip_set = 1'b1;
            trip_irq = 1'b1;
         end
         CMD_CLEAR_TRIP: begin
            trip_set = 1'b0;
            trip_irq = 1'b0;
         end
         CMD_SET_FORCE:     force_on = value[0];
         default: ;
      endcase

      // Dead band off: both outputs follow the qualifier level
      if (cfg_db_on) begin
         outs.pwm_a = db_a;
         outs.pwm_b = db_b;
      end else begin
         outs.pwm_a = aq_level;
         outs.pwm_b = aq_level;
      end
      // Trip wins over everything: A high, B low
      if (trip_set) begin
         outs.pwm_a = 1'b1;
         outs.pwm_b = 1'b0;
      end
      outs.adc_trigger    = at_zero;
      outs.trip_latched   = trip_set;
      outs.trip_interrupt = trip_irq;
      return outs;
   endfunction

   // ---------------------------------------------------------------------------
   // Clock, cycle limit and failure reporting
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop if the run hangs: any leftover expectation ends up here
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_outputs.size());
      $display("Some tests failed");
      $finish;
   end

   task automatic note_failure(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic compare_field(string field, logic expected, logic got);
      if (got !== expected)
         note_failure($sformatf("response %0d %s: expected %b got %b",
                                response_count, field, expected, got));
   endtask

   // ---------------------------------------------------------------------------
   // Response side: draw a stall per transaction, then accept and check
   // ---------------------------------------------------------------------------
   initial begin
      int              stall;
      pwm_outputs_type exp_out;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         // A requested long hold-off replaces the usual stall once
         if (hold_off_cycles > 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);

         if (pending_outputs.size() == 0) begin
            note_failure($sformatf("response %0d arrived with nothing expected",
                                   response_count));
         end else begin
            exp_out = pending_outputs.pop_front();
            compare_field("pwm_a",          exp_out.pwm_a,          rsp_ch.pwm_a);
            compare_field("pwm_b",          exp_out.pwm_b,          rsp_ch.pwm_b);
            compare_field("adc_trigger",    exp_out.adc_trigger,    rsp_ch.adc_trigger);
            compare_field("trip_latched",   exp_out.trip_latched,   rsp_ch.trip_latched);
            compare_field("trip_interrupt", exp_out.trip_interrupt, rsp_ch.trip_interrupt);
         end
         response_count++;
      end
   end

   // ---------------------------------------------------------------------------
   // Request side and CSR helpers
   // ---------------------------------------------------------------------------

   // Offer one request after a random gap; hold it until accepted, then predict.
   // Valid stays high on return so back-to-back transactions never drop it.
   task automatic send_request(logic [CMD_BITS-1:0] cmd, logic [VALUE_BITS-1:0] value,
                               logic pin);
      int gap;
      @(negedge clock);
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.cmd      = cmd;
      req_ch.value    = value;
      req_ch.trip_pin = pin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_outputs.push_back(predict_pwm_outputs(cmd, value, pin));
   endtask

   // Drop valid, drain every expected response and let the pipeline settle
   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_DEAD_BAND_ENABLE: cfg_db_on    = data[0];
         CSR_DEAD_BAND_DELAY:  cfg_db_ticks = data[DLY_W-1:0];
         CSR_TRIP_ENABLE:      cfg_trip_on  = data[0];
         default: ;
      endcase
   endtask

   // Only called with the block drained
   task automatic apply_settings(logic db_on, logic [DLY_W-1:0] db_ticks, logic trip_on);
      write_csr(CSR_DEAD_BAND_ENABLE, CSR_DATA_BITS'(db_on));
      write_csr(CSR_DEAD_BAND_DELAY,  CSR_DATA_BITS'(db_ticks));
      write_csr(CSR_TRIP_ENABLE,      CSR_DATA_BITS'(trip_on));
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Zero period, shadow loading, turnaround, compare above the period and
   // compare matches in both directions, all at the reset configuration
   task automatic test_time_base_edges();
      send_request(CMD_TICK, '0, 1'b0);                 // zero period: stays at zero
      send_request(CMD_WRITE_PERIOD, 16'hFFFF, 1'b0);   // all ones, overwritten below
      send_request(CMD_WRITE_PERIOD, 16'd3, 1'b0);
      send_request(CMD_WRITE_COMPARE, 16'hFFFF, 1'b0);  // beyond the period: no match
      repeat (5) send_request(CMD_TICK, '0, 1'b0);      // load, count up, turn around
      send_request(CMD_WRITE_COMPARE, 16'd2, 1'b0);
      repeat (6) send_request(CMD_TICK, '0, 1'b0);      // reload at zero, match up/down
   endtask

   // Force high, trip from pin and software, clear while the pin is active,
   // and the reserved command codes
   task automatic test_trip_and_force();
      send_request(CMD_SET_FORCE, 16'd1, 1'b0);
      send_request(CMD_TICK, '0, 1'b1);                 // pin trips the latch
      send_request(CMD_CLEAR_TRIP, '0, 1'b1);           // pin ignored off a tick
      send_request(CMD_TICK, '0, 1'b1);                 // latch sets again
      send_request(CMD_CLEAR_TRIP, '0, 1'b0);
      send_request(CMD_FORCE_TRIP, '0, 1'b0);
      send_request(CMD_SET_FORCE, 16'hFFFE, 1'b0);      // bit 0 low releases force
      send_request(CMD_RESERVED_LO, 16'h5A5A, 1'b0);
      send_request(CMD_RESERVED_HI, 16'hFFFF, 1'b1);
      send_request(CMD_CLEAR_TRIP, '0, 1'b0);
   endtask

   // Mostly ticks over short periods with random writes, trips and force
   task automatic test_random_phase(int num_items, int period_max);
      int                    pick;
      logic [CMD_BITS-1:0]   cmd;
      logic [VALUE_BITS-1:0] value;
      logic                  pin;
      for (int i = 0; i < num_items; i++) begin
         // Alternate idling stretches with full-rate stretches
         if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         pick  = $urandom_range(0, 99);
         value = VALUE_BITS'($urandom);
         pin   = ($urandom_range(0, 49) == 0);
         if (pick < 68) begin
            cmd = CMD_TICK;
         end else if (pick < 78) begin
            cmd = CMD_WRITE_COMPARE;
            if ($urandom_range(0, 4) != 0) value = VALUE_BITS'($urandom_range(0, period_max + 1));
         end else if (pick < 85) begin
            cmd   = CMD_WRITE_PERIOD;
            value = VALUE_BITS'($urandom_range(0, period_max));
         end else if (pick < 87) begin
            cmd = CMD_FORCE_TRIP;
         end else if (pick < 94) begin
            cmd = CMD_CLEAR_TRIP;
         end else if (pick < 98) begin
            cmd      = CMD_SET_FORCE;
            value[0] = ($urandom_range(0, 2) == 0);
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_RESERVED_LO : CMD_RESERVED_HI;
         end
         send_request(cmd, value, pin);
      end
      gaps_on = 1'b1;
   endtask

   // Hold the response side off for a long stretch while requests keep coming
   // at full rate, so the block fills and stalls its input
   task automatic test_backpressure();
      gaps_on         = 1'b0;
      hold_off_cycles = 80;
      repeat (60) send_request(CMD_TICK, '0, 1'b0);
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_TICK;
      req_ch.value     = '0;
      req_ch.trip_pin  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DEAD_BAND_ENABLE;
      csr_write_data   = '0;
      reset_pwm_model();
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Reset configuration: dead band on with zero delay, trip pin enabled
      test_time_base_edges();
      test_trip_and_force();
      wait_quiet();

      apply_settings(1'b1, 10'd3, 1'b1);
      test_random_phase(180, 20);
      wait_quiet();

      // Dead band bypassed: A and B both follow the qualifier
      apply_settings(1'b0, 10'd5, 1'b1);
      test_random_phase(180, 12);
      wait_quiet();

      // Longest delay, trip pin masked
      apply_settings(1'b1, 10'd1023, 1'b0);
      test_random_phase(180, 30);
      wait_quiet();

      apply_settings(1'b1, 10'd1, 1'b1);
      test_random_phase(180, 6);
      wait_quiet();

      apply_settings(1'b1, 10'd8, 1'b0);
      test_random_phase(180, 40);
      test_backpressure();
      wait_quiet();

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
